>>> src/dpss_pkg.sv
// Shared constants, codes and item types for the pair set with stack and queue removal.
`default_nettype none
package dpss_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int VAL_W = 32;
	localparam int HELD_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT     = 2'd0,
		CMD_REMOVE     = 2'd1,
		CMD_POP_NEWEST = 2'd2,
		CMD_POP_OLDEST = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [VAL_W-1:0]  first_value;
		logic signed [VAL_W-1:0]  second_value;
	} in_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  out_first;
		logic signed [VAL_W-1:0]  out_second;
		logic [HELD_W-1:0]        entries_held;
	} out_t;

	typedef struct packed {
		logic                     match_en;
		logic                     apply_en;
		cmd_t                     cmd;
		logic signed [VAL_W-1:0]  first;
		logic signed [VAL_W-1:0]  second;
		logic [CNT_W-1:0]         count;
		logic                     found;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> src/dpss_cell.sv
// One storage cell of the pair table: holds a pair, flags a hit and shifts toward the head.
`default_nettype none
module dpss_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpss_pkg::cell_ctl_t                 ctl,
	input  logic [dpss_pkg::IDX_W-1:0]          index,
	input  logic signed [dpss_pkg::VAL_W-1:0]   nxt_first,
	input  logic signed [dpss_pkg::VAL_W-1:0]   nxt_second,
	input  logic                                shift_in,
	output logic                                shift_out,
	output logic                                hit,
	output logic signed [dpss_pkg::VAL_W-1:0]   first,
	output logic signed [dpss_pkg::VAL_W-1:0]   second
);

	logic [dpss_pkg::CNT_W-1:0] idx_ext;
	logic                       occ;
	logic                       hit_nxt;
	logic                       hit_q;
	logic                       load_new;
	logic                       load_shift;
	logic signed [dpss_pkg::VAL_W-1:0] first_q;
	logic signed [dpss_pkg::VAL_W-1:0] second_q;

	assign idx_ext = dpss_pkg::CNT_W'(index);
	assign occ = idx_ext < ctl.count;

	always_comb begin
		case (ctl.cmd)
			dpss_pkg::CMD_POP_NEWEST: hit_nxt = occ && ((idx_ext + 1'b1) == ctl.count);
			dpss_pkg::CMD_POP_OLDEST: hit_nxt = occ && (idx_ext == '0);
			default: hit_nxt = occ && (first_q == ctl.first) && (second_q == ctl.second);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.match_en) begin
			hit_q <= hit_nxt;
		end
	end

	assign shift_out = shift_in | hit_q;
	assign load_new = ctl.apply_en && (ctl.cmd == dpss_pkg::CMD_INSERT) && !ctl.found
		&& (idx_ext == ctl.count);
	assign load_shift = ctl.apply_en && (ctl.cmd != dpss_pkg::CMD_INSERT) && shift_out;

	always_ff @(posedge clk) begin
		if (load_new) begin
			first_q  <= ctl.first;
			second_q <= ctl.second;
		end else if (load_shift) begin
			first_q  <= nxt_first;
			second_q <= nxt_second;
		end
	end

	assign hit = hit_q;
	assign first = first_q;
	assign second = second_q;

endmodule
`default_nettype wire

>>> src/dedup_pair_set_stack_queue_unit.sv
// Top level of the ordered pair set: command sequencer, cell row and result register.
//
// The block keeps up to 64 unique pairs of signed 32-bit values in insertion order, one
// pair per cell of a row, and answers insert, remove, pop newest and pop oldest commands
// with one result item each. For each item the command is captured, then
// every cell compares its pair (or its position, for pops) at once, then the row shifts
// one step toward the head to close the gap or the next free cell takes the new pair.
// A new item is taken in the cycle after that, while the finished result may still wait
// in the output register; the result register holds one item, so a stalled output holds
// the row back only when a second result is ready. The table is empty after reset and
// needs no clearing pass.
`default_nettype none
module dedup_pair_set_stack_queue_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  dpss_pkg::in_t   cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output dpss_pkg::out_t  rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_APPLY
	} state_t;

	state_t                            state_q;
	dpss_pkg::cmd_t                    cmd_q;
	logic signed [dpss_pkg::VAL_W-1:0] first_q;
	logic signed [dpss_pkg::VAL_W-1:0] second_q;
	logic [dpss_pkg::CNT_W-1:0]        count_q;
	logic                              rsp_valid_q;
	dpss_pkg::out_t                    rsp_q;

	dpss_pkg::cell_ctl_t               ctl;
	logic [dpss_pkg::CAPACITY-1:0]     hit;
	logic [dpss_pkg::CAPACITY:0]       shift;
	logic signed [dpss_pkg::VAL_W-1:0] cell_first [dpss_pkg::CAPACITY];
	logic signed [dpss_pkg::VAL_W-1:0] cell_second [dpss_pkg::CAPACITY];

	logic                              found;
	logic                              apply_go;
	logic signed [dpss_pkg::VAL_W-1:0] pick_first;
	logic signed [dpss_pkg::VAL_W-1:0] pick_second;
	dpss_pkg::status_t                 status_nxt;
	logic signed [dpss_pkg::VAL_W-1:0] out_first_nxt;
	logic signed [dpss_pkg::VAL_W-1:0] out_second_nxt;
	logic [dpss_pkg::CNT_W-1:0]        count_nxt;

	assign found = |hit;
	assign apply_go = (state_q == S_APPLY) && !(rsp_valid_q && rsp_stall);

	assign ctl.match_en = (state_q == S_MATCH);
	assign ctl.apply_en = apply_go;
	assign ctl.cmd = cmd_q;
	assign ctl.first = first_q;
	assign ctl.second = second_q;
	assign ctl.count = count_q;
	assign ctl.found = found;

	assign shift[0] = 1'b0;

	for (genvar i = 0; i < dpss_pkg::CAPACITY; i++) begin : g_cell
		if (i == dpss_pkg::CAPACITY - 1) begin : g_tail
			dpss_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.index      (dpss_pkg::IDX_W'(i)),
				.nxt_first  (cell_first[i]),
				.nxt_second (cell_second[i]),
				.shift_in   (shift[i]),
				.shift_out  (shift[i+1]),
				.hit        (hit[i]),
				.first      (cell_first[i]),
				.second     (cell_second[i])
			);
		end else begin : g_body
			dpss_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.index      (dpss_pkg::IDX_W'(i)),
				.nxt_first  (cell_first[i+1]),
				.nxt_second (cell_second[i+1]),
				.shift_in   (shift[i]),
				.shift_out  (shift[i+1]),
				.hit        (hit[i]),
				.first      (cell_first[i]),
				.second     (cell_second[i])
			);
		end
	end

	always_comb begin
		pick_first = '0;
		pick_second = '0;
		for (int i = 0; i < dpss_pkg::CAPACITY; i++) begin
			if (hit[i]) begin
				pick_first = pick_first | cell_first[i];
				pick_second = pick_second | cell_second[i];
			end
		end
	end

	always_comb begin
		status_nxt = dpss_pkg::ST_ADDED;
		out_first_nxt = '0;
		out_second_nxt = '0;
		count_nxt = count_q;
		case (cmd_q)
			dpss_pkg::CMD_INSERT: begin
				if (found) begin
					status_nxt = dpss_pkg::ST_DUP;
				end else if (count_q == dpss_pkg::CNT_W'(dpss_pkg::CAPACITY)) begin
					status_nxt = dpss_pkg::ST_FULL;
				end else begin
					status_nxt = dpss_pkg::ST_ADDED;
					count_nxt = count_q + 1'b1;
				end
			end
			default: begin
				if (found) begin
					status_nxt = dpss_pkg::ST_REMOVED;
					out_first_nxt = pick_first;
					out_second_nxt = pick_second;
					count_nxt = count_q - 1'b1;
				end else if (cmd_q == dpss_pkg::CMD_REMOVE) begin
					status_nxt = dpss_pkg::ST_NOTFOUND;
				end else begin
					status_nxt = dpss_pkg::ST_EMPTY;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= dpss_pkg::CMD_INSERT;
			first_q <= '0;
			second_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && !apply_go) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd.command;
						first_q <= cmd.first_value;
						second_q <= cmd.second_value;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) begin
						rsp_q.status <= status_nxt;
						rsp_q.out_first <= out_first_nxt;
						rsp_q.out_second <= out_second_nxt;
						rsp_q.entries_held <= dpss_pkg::HELD_W'(count_nxt);
						rsp_valid_q <= 1'b1;
						count_q <= count_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Pairs are unique and pops mark a single position, so at most one cell hits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $onehot0(hit))
		else $error("more than one cell hit");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dpss_pkg::CNT_W'(dpss_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_APPLY))
		else $error("result raised outside the apply step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(apply_go && (cmd_q != dpss_pkg::CMD_INSERT) && found)
		|=> (count_q == $past(count_q) - 1'b1))
		else $error("removal did not lower the count");

endmodule
`default_nettype wire

>>> sim/tb_dedup_pair_set_stack_queue_unit.sv
// Self-checking testbench for the ordered pair set with stack and queue removal.
`timescale 1ns / 1ps
module tb_dedup_pair_set_stack_queue_unit;

	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct {
		dpss_pkg::in_t  item;
		bit             typed;
		dpss_pkg::out_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	dpss_pkg::in_t  cmd;
	logic rsp_valid;
	logic rsp_stall;
	dpss_pkg::out_t rsp;

	logic [dpss_pkg::VAL_W-1:0] held_first [dpss_pkg::CAPACITY];
	logic [dpss_pkg::VAL_W-1:0] held_second [dpss_pkg::CAPACITY];
	int held_count = 0;

	dpss_pkg::out_t pending [$];
	plan_row_t plan [$];
	dpss_pkg::out_t owed;
	int errors = 0;
	int cycles = 0;
	bit steady = 1'b0;

	dedup_pair_set_stack_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic dpss_pkg::out_t apply_to_pair_set(input dpss_pkg::in_t item);
		dpss_pkg::out_t res;
		int hit;
		int take;
		res = '0;
		hit = -1;
		take = -1;
		for (int i = 0; i < held_count; i++) begin
			if (hit < 0 && held_first[i] == item.first_value &&
					held_second[i] == item.second_value)
				hit = i;
		end
		case (item.command)
			dpss_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					res.status = dpss_pkg::ST_DUP;
				end else if (held_count >= dpss_pkg::CAPACITY) begin
					res.status = dpss_pkg::ST_FULL;
				end else begin
					held_first[held_count] = item.first_value;
					held_second[held_count] = item.second_value;
					held_count++;
					res.status = dpss_pkg::ST_ADDED;
				end
			end
			dpss_pkg::CMD_REMOVE: begin
				if (hit < 0)
					res.status = dpss_pkg::ST_NOTFOUND;
				else
					take = hit;
			end
			default: begin
				if (held_count == 0)
					res.status = dpss_pkg::ST_EMPTY;
				else if (item.command == dpss_pkg::CMD_POP_NEWEST)
					take = held_count - 1;
				else
					take = 0;
			end
		endcase
		if (take >= 0) begin
			res.status = dpss_pkg::ST_REMOVED;
			res.out_first = held_first[take];
			res.out_second = held_second[take];
			for (int i = take; i + 1 < held_count; i++) begin
				held_first[i] = held_first[i + 1];
				held_second[i] = held_second[i + 1];
			end
			held_count--;
		end
		res.entries_held = held_count[dpss_pkg::HELD_W-1:0];
		return res;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic logic [dpss_pkg::VAL_W-1:0] pool_value();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	task automatic add_row(input dpss_pkg::cmd_t c, input logic [dpss_pkg::VAL_W-1:0] a,
			input logic [dpss_pkg::VAL_W-1:0] b, input bit typed,
			input dpss_pkg::status_t st, input logic [dpss_pkg::VAL_W-1:0] ra,
			input logic [dpss_pkg::VAL_W-1:0] rb, input int held);
		plan_row_t row;
		row.item.command = c;
		row.item.first_value = a;
		row.item.second_value = b;
		row.typed = typed;
		row.want.status = st;
		row.want.out_first = ra;
		row.want.out_second = rb;
		row.want.entries_held = held[dpss_pkg::HELD_W-1:0];
		plan.push_back(row);
	endtask

	task automatic send_item(input dpss_pkg::in_t item, input bit typed,
			input dpss_pkg::out_t want);
		int gap;
		dpss_pkg::out_t predicted;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do
			@(posedge clk);
		while (cmd_stall);
		predicted = apply_to_pair_set(item);
		pending.push_back(typed ? want : predicted);
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		rsp_stall <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int hold;
		bit stalled;
		hold = 0;
		stalled = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (stalled) begin
				stalled = 1'b0;
				rsp_stall <= 1'b0;
				hold = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
						: $urandom_range(1, 20);
			end else begin
				hold = idle_len();
				if (hold > 0) begin
					stalled = 1'b1;
					rsp_stall <= 1'b1;
					hold--;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending.size() == 0) begin
				errors++;
				$error("result item with no expectation pending");
			end else begin
				owed = pending.pop_front();
				if (rsp.status !== owed.status) begin
					errors++;
					$error("status: expected %0d, got %0d", owed.status, rsp.status);
				end
				if (rsp.out_first !== owed.out_first) begin
					errors++;
					$error("out_first: expected %0d, got %0d", owed.out_first, rsp.out_first);
				end
				if (rsp.out_second !== owed.out_second) begin
					errors++;
					$error("out_second: expected %0d, got %0d", owed.out_second,
							rsp.out_second);
				end
				if (rsp.entries_held !== owed.entries_held) begin
					errors++;
					$error("entries_held: expected %0d, got %0d", owed.entries_held,
							rsp.entries_held);
				end
			end
		end
	end

	initial begin
		dpss_pkg::in_t item;
		mix_t mix;
		int sent;
		int span;
		int r;
		int s;
		int pick;
		int insert_pct;
		add_row(dpss_pkg::CMD_POP_NEWEST, 32'h0, 32'h0, 1, dpss_pkg::ST_EMPTY,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_POP_OLDEST, 32'h1234, 32'h5678, 1, dpss_pkg::ST_EMPTY,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_REMOVE, 32'd5, 32'd6, 1, dpss_pkg::ST_NOTFOUND,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 1);
		add_row(dpss_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 2);
		add_row(dpss_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1, dpss_pkg::ST_DUP,
				32'h0, 32'h0, 2);
		add_row(dpss_pkg::CMD_INSERT, 32'h0, 32'h0, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 3);
		add_row(dpss_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 4);
		add_row(dpss_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 5);
		add_row(dpss_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 6);
		add_row(dpss_pkg::CMD_REMOVE, 32'h0, 32'h1, 1, dpss_pkg::ST_NOTFOUND,
				32'h0, 32'h0, 6);
		add_row(dpss_pkg::CMD_REMOVE, 32'h0, 32'h0, 1, dpss_pkg::ST_REMOVED,
				32'h0, 32'h0, 5);
		add_row(dpss_pkg::CMD_POP_OLDEST, 32'h0, 32'h0, 1, dpss_pkg::ST_REMOVED,
				32'h8000_0000, 32'h7FFF_FFFF, 4);
		add_row(dpss_pkg::CMD_POP_NEWEST, 32'h0, 32'h0, 1, dpss_pkg::ST_REMOVED,
				32'hFFFF_FFFF, 32'h0, 3);
		add_row(dpss_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, dpss_pkg::ST_REMOVED,
				32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
		add_row(dpss_pkg::CMD_INSERT, 32'h0, 32'h0, 1, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 3);
		add_row(dpss_pkg::CMD_INSERT, 32'h1234_5678, 32'hFFFF_FFFB, 0, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 32'h8000_0000, 0, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_POP_OLDEST, 32'h0, 32'h0, 0, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_POP_NEWEST, 32'h0, 32'h0, 0, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_POP_NEWEST, 32'h0, 32'h0, 0, dpss_pkg::ST_ADDED,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_POP_NEWEST, 32'h0, 32'h0, 1, dpss_pkg::ST_EMPTY,
				32'h0, 32'h0, 0);
		add_row(dpss_pkg::CMD_REMOVE, 32'h0, 32'h0, 1, dpss_pkg::ST_NOTFOUND,
				32'h0, 32'h0, 0);

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (plan[i])
			send_item(plan[i].item, plan[i].typed, plan[i].want);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			mix = (r < 4) ? MIX_FILL : (r < 7) ? MIX_DRAIN : MIX_EVEN;
			insert_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 15 : 45;
			span = $urandom_range(30, 150);
			steady = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				s = $urandom_range(0, 9);
				item.first_value = $urandom;
				item.second_value = $urandom;
				if (r < insert_pct) begin
					item.command = dpss_pkg::CMD_INSERT;
					if (s < 2 && held_count > 0) begin
						pick = $urandom_range(0, held_count - 1);
						item.first_value = held_first[pick];
						item.second_value = held_second[pick];
					end else if (s < 6) begin
						item.first_value = pool_value();
						item.second_value = pool_value();
					end
				end else if (r < insert_pct + (100 - insert_pct) / 2) begin
					item.command = dpss_pkg::CMD_REMOVE;
					if (s < 5 && held_count > 0) begin
						pick = $urandom_range(0, held_count - 1);
						item.first_value = held_first[pick];
						item.second_value = held_second[pick];
					end else if (s < 8) begin
						item.first_value = pool_value();
						item.second_value = pool_value();
					end
				end else if (s < 5) begin
					item.command = dpss_pkg::CMD_POP_NEWEST;
				end else begin
					item.command = dpss_pkg::CMD_POP_OLDEST;
				end
				send_item(item, 1'b0, '0);
				sent++;
			end
		end
		cmd_valid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> dedup_pair_set_stack_queue_unit.f
src/dpss_pkg.sv
src/dpss_cell.sv
src/dedup_pair_set_stack_queue_unit.sv
sim/tb_dedup_pair_set_stack_queue_unit.sv
